// ===== design/ax25hp_pkg.sv =====
// shared types and constants for the ax25 header parser
package ax25hp_pkg;

  localparam int unsigned ADDR_BYTES = 7;
  localparam logic [7:0]  SSID_MASK  = 8'd30;
  localparam logic [6:0]  PRINT_LOW  = 7'd32;
  localparam logic [6:0]  PRINT_HIGH = 7'd127;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ADDR_CHAR = 2'd0,
    KIND_ADDR_END  = 2'd1,
    KIND_INFO      = 2'd2,
    KIND_SUMMARY   = 2'd3
  } kind_t;

  // parse phase, one-hot
  typedef enum logic [2:0] {
    PH_ADDR = 3'b001,
    PH_SKIP = 3'b010,
    PH_INFO = 3'b100
  } phase_t;

  typedef struct packed {
    logic       first_of_frame;
    logic [7:0] frame_len;
    logic [7:0] frame_byte;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [5:0] address_number;
    logic [2:0] char_slot;
    logic [3:0] ssid;
    logic       command_heard;
    logic       last_address;
    logic [7:0] info_count;
    logic       last_of_run;
  } res_t;

  // results produced by one byte, in order
  typedef struct packed {
    logic [1:0] n;
    res_t       e0;
    res_t       e1;
  } push_t;

endpackage

// ===== design/ax25hp_core.sv =====
// input register, frame parse state and per-byte result logic
module ax25hp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ax25hp_pkg::in_item_t in_item,
  input  logic                room,
  output ax25hp_pkg::push_t   push
);
  import ax25hp_pkg::*;

  logic       in_v_r;
  in_item_t   in_r;
  logic       proc;

  logic [7:0] pos_r,  pos_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] abi_r,  abi_nxt;
  logic [5:0] acnt_r, acnt_nxt;
  logic [2:0] kept_r, kept_nxt;
  logic [7:0] icnt_r, icnt_nxt;
  logic [1:0] cpl_r,  cpl_nxt;

  // state after an optional start-of-frame clear
  logic [7:0] pos;
  phase_t     ph;
  logic [2:0] abi;
  logic [5:0] acnt;
  logic [2:0] kept;
  logic [7:0] icnt;
  logic [1:0] cpl;

  logic [7:0] b, len, remain;
  logic [6:0] c;
  logic       va, vb;
  res_t       ra, rb;

  assign in_ready = !in_v_r || room;
  assign proc     = in_v_r && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
  end

  always_comb begin
    b      = in_r.frame_byte;
    len    = in_r.frame_len;
    c      = b[7:1];

    pos  = in_r.first_of_frame ? 8'd0    : pos_r;
    ph   = in_r.first_of_frame ? PH_ADDR : phase_r;
    abi  = in_r.first_of_frame ? 3'd0    : abi_r;
    acnt = in_r.first_of_frame ? 6'd0    : acnt_r;
    kept = in_r.first_of_frame ? 3'd0    : kept_r;
    icnt = in_r.first_of_frame ? 8'd0    : icnt_r;
    cpl  = in_r.first_of_frame ? 2'd0    : cpl_r;

    remain = len - pos;

    pos_nxt = (pos != 8'hff) ? pos + 8'd1 : pos;
    va = 1'b0;
    vb = 1'b0;
    ra = '0;
    rb = '0;

    if (pos < len) begin
      // too few bytes left for another address
      if (ph == PH_ADDR && abi == 3'd0 && remain < 8'(ADDR_BYTES)) begin
        ph  = PH_SKIP;
        cpl = 2'd2;
      end

      if (ph == PH_ADDR) begin
        if (abi < 3'd6) begin
          if (c > PRINT_LOW && c < PRINT_HIGH) begin
            va                = 1'b1;
            ra.kind           = KIND_ADDR_CHAR;
            ra.data_byte      = {1'b0, c};
            ra.address_number = acnt;
            ra.char_slot      = kept;
            ra.info_count     = icnt;
            if (kept != 3'd7) begin
              kept = kept + 3'd1;
            end
          end
          abi = abi + 3'd1;
        end else begin
          va                = 1'b1;
          ra.kind           = KIND_ADDR_END;
          ra.address_number = acnt;
          ra.ssid           = 4'((b & SSID_MASK) >> 1);
          ra.command_heard  = b[7];
          ra.last_address   = b[0];
          ra.info_count     = icnt;
          if (acnt != 6'd63) begin
            acnt = acnt + 6'd1;
          end
          abi  = 3'd0;
          kept = 3'd0;
          if (b[0]) begin
            ph  = PH_SKIP;
            cpl = 2'd2;
          end
        end
      end else if (ph == PH_SKIP && cpl != 2'd0) begin
        cpl = cpl - 2'd1;
        if (cpl == 2'd0) begin
          ph = PH_INFO;
        end
      end else begin
        ph = PH_INFO;
        // trailing crc bytes are not info
        if ({1'b0, pos} + 9'd2 < {1'b0, len}) begin
          if (icnt != 8'hff) begin
            icnt = icnt + 8'd1;
          end
          va            = 1'b1;
          ra.kind       = KIND_INFO;
          ra.data_byte  = b;
          ra.info_count = icnt;
        end
      end

      if ({1'b0, pos} + 9'd1 == {1'b0, len}) begin
        vb                = 1'b1;
        rb.kind           = KIND_SUMMARY;
        rb.address_number = acnt;
        rb.info_count     = icnt;
        rb.last_of_run    = 1'b1;
      end
      ra.last_of_run = !vb;
    end

    phase_nxt = ph;
    abi_nxt   = abi;
    acnt_nxt  = acnt;
    kept_nxt  = kept;
    icnt_nxt  = icnt;
    cpl_nxt   = cpl;

    push.n  = proc ? (2'(va) + 2'(vb)) : 2'd0;
    push.e0 = va ? ra : rb;
    push.e1 = rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_ADDR;
      abi_r   <= '0;
      acnt_r  <= '0;
      kept_r  <= '0;
      icnt_r  <= '0;
      cpl_r   <= '0;
    end else if (proc) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      abi_r   <= abi_nxt;
      acnt_r  <= acnt_nxt;
      kept_r  <= kept_nxt;
      icnt_r  <= icnt_nxt;
      cpl_r   <= cpl_nxt;
    end
  end

endmodule

// ===== design/ax25hp_fifo.sv =====
// four-entry result queue taking up to two words per cycle
module ax25hp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  ax25hp_pkg::push_t push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ax25hp_pkg::res_t  out_res
);
  import ax25hp_pkg::*;

  localparam int unsigned DEPTH = 4;

  res_t       mem_r [DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic       pop;
  logic [1:0] wr_ptr1;

  assign room      = count_r <= 3'(DEPTH - 2);
  assign out_valid = count_r != 3'd0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr1   = wr_ptr_r + 2'd1;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push.n;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + 3'(push.n) - 3'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(DEPTH))
    else $error("result queue over capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("push into queue without room");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 3'd1 && pop && push.n == 2'd0) |=> !out_valid)
    else $error("queue did not drain");
`endif

endmodule

// ===== design/ax25_header_parser_top.sv =====
// top level of the ax25 frame address and info splitter
// usage:
//   in_*  : one frame byte per word; in_tdata = frame_byte, frame_len;
//           in_tuser marks the first byte of a frame and restarts parsing
//   out_* : one result per word; out_tuser = kind (address char, address
//           end, info byte, frame summary), out_tlast marks the final
//           result caused by one input byte
// path: an accepted byte is held in the input register, is parsed from there
//   once the result queue has room, and its results are written into the queue,
//   from which the first result is offered
// throughput: one byte per cycle while out_tready is high and each byte gives at
//   most one result; the final byte of a frame may give two results, which then
//   leave the output one after the other. the four-entry result queue sets this figure
// stall: when out_tready is low the queue fills, the input register holds
//   its byte and in_tready drops once fewer than two queue slots are free
// reset: rst_n low empties the queue and input register and returns the
//   parser to the address phase with all counters at zero
module ax25_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // frame_byte[7:0], frame_len[15:8]
  input  logic        in_tuser,   // first_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  // data_byte[7:0], address_number[13:8], char_slot[16:14], ssid[20:17],
  // command_heard[21], last_address[22], info_count[30:23], zero[31]
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last_of_run
);
  import ax25hp_pkg::*;

  in_item_t in_item;
  push_t    push;
  logic     room;
  res_t     res;

  // unpack the input word
  assign in_item.frame_byte     = in_tdata[7:0];
  assign in_item.frame_len      = in_tdata[15:8];
  assign in_item.first_of_frame = in_tuser;

  // per-byte parse logic between input register and result queue
  ax25hp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .room     (room),
    .push     (push)
  );

  // result queue, registered output side
  ax25hp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result word
  assign out_tdata = {1'b0, res.info_count, res.last_address, res.command_heard,
                      res.ssid, res.char_slot, res.address_number, res.data_byte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_of_run;

endmodule
